/* src/pimf_pkg.sv */
`default_nettype none

package pimf_pkg;

	typedef struct packed {
		logic [15:0] pulse_length;
		logic        is_end;
	} in_beat_t;

	typedef struct packed {
		logic        out_kind;
		logic [15:0] out_length;
		logic        last;
	} out_beat_t;

	localparam logic [15:0] GAP_THRESHOLD_RESET = 16'd400;

	localparam logic KIND_LENGTH = 1'b0;
	localparam logic KIND_MARKER = 1'b1;

endpackage

`default_nettype wire

/* src/pulse_interval_merger_and_framer_top.sv */
// Pulse interval merger and framer.
//
// Input channel (in_valid/in_ready/in_data) carries one pulse length or a stream
// end marker per beat. Output channel (out_valid/out_ready/out_data) carries
// cleaned lengths and end-of-burst markers; last marks the final result beat
// caused by one input beat. An input beat gives zero, one or two result beats.
// cfg_we/cfg_wdata write the gap threshold; write it only while the block idles.
//
// An accepted beat lands in an input register and is processed once the
// four-entry result queue has room for two beats; its results are written
// into the queue together and offered from there. One input beat is taken
// per cycle while the queue drains; the output side moves one beat per cycle
// while the receiver is ready, so a stream whose inputs each give two results
// is held back by the output side.
// A stalled receiver fills the queue, and in_ready drops once the input register
// holds a beat that cannot be processed. No results are lost.
// Reset clears the queue, the merge history and the framer, and loads the gap
// threshold with 400.
`default_nettype none

module pulse_interval_merger_and_framer_top #(
	parameter int LENGTH_BITS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire pimf_pkg::in_beat_t  in_data,
	output logic                     out_valid,
	input  wire                      out_ready,
	output pimf_pkg::out_beat_t      out_data,
	input  wire                      cfg_we,
	input  wire  [15:0]              cfg_wdata
);
	import pimf_pkg::*;

	localparam int LB = LENGTH_BITS;
	localparam int EW = LENGTH_BITS + 16;

	// input register
	logic     valid_s1;
	in_beat_t beat_s1;

	// configuration and state
	logic [15:0]   thr_q;
	logic [LB-1:0] newest_q;
	logic [LB-1:0] older_q;
	logic          leading_q;
	logic          gap_rep_q;
	logic [LB-1:0] held_q;
	logic          held_valid_q;
	logic          in_burst_q;

	// result queue
	out_beat_t   fifo_q [0:3];
	logic [1:0]  wptr_q;
	logic [1:0]  rptr_q;
	logic [2:0]  cnt_q;

	logic          proc;
	logic          pop;
	logic [EW-1:0] in_ext;
	logic [LB-1:0] len_in;
	logic [LB:0]   sum_w;
	logic [LB-1:0] cur_len;
	logic [EW-1:0] cur_ext;
	logic [EW-1:0] thr_ext;
	logic [EW-1:0] older_ext;
	logic [EW-1:0] held_ext;
	logic          both_nz;
	logic          gap;
	logic          leading1;
	logic          marker;
	logic          push;
	logic          emit_marker;
	logic          ib_m;
	logic          hv_m;
	logic          emit_held;
	logic          emit_older;
	logic [1:0]    nres;
	out_beat_t     res0;
	out_beat_t     res1;
	logic [LB-1:0] newest_d;
	logic [LB-1:0] older_d;
	logic          leading_d;
	logic          gap_rep_d;
	logic          held_valid_d;
	logic          in_burst_d;
	logic          load_held;

	assign pop       = out_valid && out_ready;
	assign proc      = valid_s1 && (cnt_q <= 3'd2);
	assign in_ready  = !valid_s1 || proc;
	assign out_valid = (cnt_q != 3'd0);
	assign out_data  = fifo_q[rptr_q];

	always_comb begin
		in_ext    = {{LB{1'b0}}, beat_s1.pulse_length};
		len_in    = in_ext[LB-1:0];
		sum_w     = {1'b0, len_in} + {1'b0, older_q};
		both_nz   = (newest_q != '0) && (older_q != '0);
		// merge into the older length when the newest one is empty
		if (newest_q == '0) begin
			cur_len = sum_w[LB] ? {LB{1'b1}} : sum_w[LB-1:0];
		end else begin
			cur_len = len_in;
		end
		cur_ext   = {16'd0, cur_len};
		thr_ext   = {{LB{1'b0}}, thr_q};
		older_ext = {16'd0, older_q};
		held_ext  = {16'd0, held_q};
		gap       = cur_ext > thr_ext;
		leading1  = leading_q || gap;

		if (beat_s1.is_end) begin
			marker    = 1'b1;
			push      = 1'b0;
			newest_d  = '0;
			older_d   = '0;
			leading_d = 1'b1;
			gap_rep_d = gap_rep_q;
		end else begin
			marker    = gap && !gap_rep_q;
			push      = both_nz && !leading1;
			newest_d  = cur_len;
			older_d   = newest_q;
			leading_d = both_nz ? 1'b0 : leading1;
			gap_rep_d = push ? 1'b0 : (gap_rep_q || gap);
		end

		// framer: marker first, then the pushed length
		emit_marker = marker && in_burst_q && !held_valid_q;
		ib_m        = marker ? 1'b0 : in_burst_q;
		hv_m        = marker ? 1'b0 : held_valid_q;
		load_held   = push && !ib_m;
		emit_held   = push && ib_m && hv_m;
		emit_older  = push && ib_m;
		if (push) begin
			in_burst_d   = 1'b1;
			held_valid_d = !ib_m;
		end else begin
			in_burst_d   = ib_m;
			held_valid_d = hv_m;
		end

		res0 = '{out_kind: KIND_MARKER, out_length: 16'd0, last: 1'b1};
		res1 = '{out_kind: KIND_LENGTH, out_length: older_ext[15:0], last: 1'b1};
		if (emit_held) begin
			res0 = '{out_kind: KIND_LENGTH, out_length: held_ext[15:0], last: 1'b0};
			nres = 2'd2;
		end else if (emit_older) begin
			res0 = '{out_kind: KIND_LENGTH, out_length: older_ext[15:0], last: 1'b1};
			nres = 2'd1;
		end else if (emit_marker) begin
			nres = 2'd1;
		end else begin
			nres = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			thr_q        <= GAP_THRESHOLD_RESET;
			newest_q     <= '0;
			older_q      <= '0;
			leading_q    <= 1'b1;
			gap_rep_q    <= 1'b0;
			held_valid_q <= 1'b0;
			in_burst_q   <= 1'b0;
			wptr_q       <= 2'd0;
			rptr_q       <= 2'd0;
			cnt_q        <= 3'd0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (proc) begin
				newest_q     <= newest_d;
				older_q      <= older_d;
				leading_q    <= leading_d;
				gap_rep_q    <= gap_rep_d;
				held_valid_q <= held_valid_d;
				in_burst_q   <= in_burst_d;
				wptr_q       <= wptr_q + nres;
			end
			if (pop) begin
				rptr_q <= rptr_q + 2'd1;
			end
			cnt_q <= cnt_q + (proc ? {1'b0, nres} : 3'd0) - {2'd0, pop};
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= in_data;
		end
		if (proc && load_held) begin
			held_q <= older_q;
		end
		if (proc && nres != 2'd0) begin
			fifo_q[wptr_q] <= res0;
		end
		if (proc && nres == 2'd2) begin
			fifo_q[wptr_q + 2'd1] <= res1;
		end
	end

endmodule

`default_nettype wire

/* src/pimf_checker.sv */
`default_nettype none

module pimf_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      out_valid,
	input wire                      out_ready,
	input wire pimf_pkg::out_beat_t out_data
);
	import pimf_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_kind == KIND_MARKER |-> out_data.out_length == 16'd0)
		else $error("end marker with nonzero length");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_kind == KIND_MARKER |-> out_data.last)
		else $error("end marker not final beat of its item");

	// both results of one item are queued together
	a_pair_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=> out_valid)
		else $error("second result of an item not available");

endmodule

bind pulse_interval_merger_and_framer_top pimf_checker u_pimf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire
